// ----- rtl/utcld_pkg.sv -----
// ----------------------------------------------------------------------------
// utcld_pkg
// Shared types and constants for the UTC to local date/time converter.
// ----------------------------------------------------------------------------
package utcld_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned OFFSET_W = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_UTC_OFFSET     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_TWELVE_HOUR = 1'd1;

    localparam logic [OFFSET_W-1:0] OFFSET_CLAMP = 8'd104;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd48;

    // Minute-of-day sum is carried biased by +720 so it stays unsigned
    localparam logic [11:0] SUM_LOW    = 12'd720;
    localparam logic [11:0] SUM_HIGH   = 12'd2160;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } utc_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   shown_hour;
        logic [MINUTE_W-1:0] minute;
        logic                is_pm;
        logic                date_valid;
    } local_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] utc_offset_biased;
        logic                use_twelve_hour;
    } cfg_t;

    // Month length; zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/utcld_calc.sv -----
// ----------------------------------------------------------------------------
// utcld_calc
// Combinational offset, minute-of-day wrap and one-day date shift.
// ----------------------------------------------------------------------------
module utcld_calc (
    input  utcld_pkg::utc_item_t   utc,
    input  utcld_pkg::cfg_t        cfg,
    output utcld_pkg::local_item_t loc
);
    import utcld_pkg::*;

    logic [OFFSET_W-1:0] biased;
    logic [10:0]         hm;
    logic [10:0]         b15;
    logic [11:0]         sum;
    logic                go_fwd;
    logic                go_back;
    logic [10:0]         wrapped;
    logic [21:0]         hq_prod;
    logic [5:0]          hq;
    logic [11:0]         hr;
    logic [4:0]          hour24;
    logic [5:0]          minute;
    logic [26:0]         cq_prod;
    logic [7:0]          cent;
    logic [YEAR_W:0]     yrem;
    logic                leap;
    logic [DAY_W-1:0]    len_in;
    logic [YEAR_W-1:0]   year_o;
    logic [MONTH_W-1:0]  month_o;
    logic [DAY_W-1:0]    day_o;
    logic [DAY_W-1:0]    len_o;
    logic [4:0]          hour12;

    always_comb
    begin
        biased = (cfg.utc_offset_biased > OFFSET_CLAMP) ? OFFSET_CLAMP
                                                        : cfg.utc_offset_biased;
        hm  = ({utc.hour, 6'd0} - {4'd0, utc.hour, 2'd0}) + {5'd0, utc.minute};
        b15 = {biased, 3'd0} + {1'b0, biased, 2'd0} + {2'b0, biased, 1'b0}
              + {3'd0, biased};
        sum = {1'b0, hm} + {1'b0, b15};

        go_back = sum < SUM_LOW;
        go_fwd  = sum >= SUM_HIGH;
        if (go_back)
            wrapped = 11'(sum + SUM_LOW);
        else if (go_fwd)
            wrapped = 11'(sum - SUM_HIGH);
        else
            wrapped = 11'(sum - SUM_LOW);

        // divide by 60 via reciprocal, with one correction step
        hq_prod = 22'(wrapped) * 22'd1093;
        hq      = hq_prod[21:16];
        hr      = {1'b0, wrapped} - ({hq, 6'd0} - {4'd0, hq, 2'd0});
        if (hr >= 12'd60)
        begin
            hour24 = 5'(hq + 6'd1);
            minute = 6'(hr - 12'd60);
        end
        else
        begin
            hour24 = hq[4:0];
            minute = hr[5:0];
        end

        // leap: year/100 via reciprocal; year%100 and (year/100)%4
        cq_prod = 27'(utc.year) * 27'd5243;
        cent    = cq_prod[26:19];
        yrem    = {1'b0, utc.year} - 15'({cent, 6'd0} + {cent, 5'd0} + {cent, 2'd0});
        if (yrem >= 15'd100)
        begin
            yrem = yrem - 15'd100;
            cent = cent + 8'd1;
        end
        leap = (utc.year[1:0] == 2'd0) && ((yrem != 15'd0) || (cent[1:0] == 2'd0));

        // the year only changes across Dec/Jan, where leap does not matter
        len_in  = month_len(utc.month, leap);
        year_o  = utc.year;
        month_o = utc.month;
        day_o   = utc.day;
        if (go_fwd)
        begin
            if (utc.day < len_in)
                day_o = utc.day + 5'd1;
            else
            begin
                day_o = 5'd1;
                if (utc.month == MONTH_DEC)
                begin
                    month_o = MONTH_JAN;
                    year_o  = utc.year + 14'd1;
                end
                else
                    month_o = utc.month + 4'd1;
            end
        end
        else if (go_back)
        begin
            if (utc.day > 5'd1)
                day_o = utc.day - 5'd1;
            else
            begin
                if (utc.month == MONTH_JAN)
                begin
                    month_o = MONTH_DEC;
                    year_o  = utc.year - 14'd1;
                end
                else
                    month_o = utc.month - 4'd1;
                day_o = month_len(month_o, leap);
            end
        end
        len_o = month_len(month_o, leap);

        hour12 = (hour24 >= 5'd12) ? hour24 - 5'd12 : hour24;
        if (hour12 == 5'd0)
            hour12 = 5'd12;

        loc.year       = year_o;
        loc.month      = month_o;
        loc.day        = day_o;
        loc.shown_hour = cfg.use_twelve_hour ? hour12 : hour24;
        loc.minute     = minute;
        loc.is_pm      = hour24 >= 5'd12;
        // month_len is zero for bad month codes, so this also checks the month
        loc.date_valid = (day_o != 5'd0) && (day_o <= len_o);
    end

endmodule

// ----- rtl/utc_offset_local_date_time_core.sv -----
// ----------------------------------------------------------------------------
// utc_offset_local_date_time_core
// UTC date/time to local date/time under a quarter-hour offset.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with the five UTC fields. Output channel:
// out_valid / out_stall with the local date, hour, minute, PM and valid flags.
// A beat is taken on each edge with valid high and stall low.
// The UTC beat lands in an input register; the conversion is one short pass
// of logic into the result register, from which the result is presented.
// One beat per cycle is sustained while out_stall is low; the input register
// refills whenever the result register is free or being emptied.
// When out_stall is held the result register holds, the input register holds
// behind it and in_stall rises once both are full.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_index
// (0: biased UTC offset, 1: twelve-hour mode); write only while idle.
// Reset clears both valid flags, sets the offset to zero (biased 48) and
// selects 24-hour form.
// ----------------------------------------------------------------------------
module utc_offset_local_date_time_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [utcld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [utcld_pkg::OFFSET_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [utcld_pkg::YEAR_W-1:0]    utc_year,
    input  logic [utcld_pkg::MONTH_W-1:0]   utc_month,
    input  logic [utcld_pkg::DAY_W-1:0]     utc_day,
    input  logic [utcld_pkg::HOUR_W-1:0]    utc_hour,
    input  logic [utcld_pkg::MINUTE_W-1:0]  utc_minute,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [utcld_pkg::YEAR_W-1:0]    local_year,
    output logic [utcld_pkg::MONTH_W-1:0]   local_month,
    output logic [utcld_pkg::DAY_W-1:0]     local_day,
    output logic [utcld_pkg::HOUR_W-1:0]    shown_hour,
    output logic [utcld_pkg::MINUTE_W-1:0]  local_minute,
    output logic                            is_pm,
    output logic                            date_valid
);
    import utcld_pkg::*;

    cfg_t        cfg_reg;
    utc_item_t   in_item_reg;
    logic        in_valid_reg;
    local_item_t res_reg;
    logic        res_valid_reg;
    local_item_t res_next;
    logic        res_load;
    logic        in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.utc_offset_biased <= OFFSET_RESET;
            cfg_reg.use_twelve_hour   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UTC_OFFSET:      cfg_reg.utc_offset_biased <= cfg_wdata;
                REG_USE_TWELVE_HOUR: cfg_reg.use_twelve_hour   <= cfg_wdata[0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign res_load = in_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !res_load;
    assign in_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load || res_load)
                in_valid_reg <= in_load;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg.year   <= utc_year;
            in_item_reg.month  <= utc_month;
            in_item_reg.day    <= utc_day;
            in_item_reg.hour   <= utc_hour;
            in_item_reg.minute <= utc_minute;
        end
        if (res_load)
            res_reg <= res_next;
    end

    utcld_calc u_calc (
        .utc (in_item_reg),
        .cfg (cfg_reg),
        .loc (res_next)
    );

    assign out_valid    = res_valid_reg;
    assign local_year   = res_reg.year;
    assign local_month  = res_reg.month;
    assign local_day    = res_reg.day;
    assign shown_hour   = res_reg.shown_hour;
    assign local_minute = res_reg.minute;
    assign is_pm        = res_reg.is_pm;
    assign date_valid   = res_reg.date_valid;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && res_valid_reg && out_stall)
        else $error("input stalled without a held item");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid)
        else $error("loaded result not presented");

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !res_load |=> in_valid_reg)
        else $error("pending item dropped");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> local_minute < 6'd60 && shown_hour < 5'd24)
        else $error("local time out of range");

endmodule

// ----- tb/sv/utc_offset_local_date_time_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_offset_local_date_time_core_test
// Self-checking bench for the UTC to local date/time converter. Beats are
// pushed through a bursty sender into a receiver with its own stall pattern.
// Each accepted UTC beat is converted in the bench under the current offset
// and hour mode. Each local beat is then checked against the oldest
// conversion still waiting.
// ----------------------------------------------------------------------------
module utc_offset_local_date_time_core_test;

    import utcld_pkg::*;

    localparam int QUARTER_BIAS  = 48;
    localparam int MINUTES_A_DAY = 1440;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 70;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 125;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [OFFSET_W-1:0]   cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [YEAR_W-1:0]     utc_year = '0;
    logic [MONTH_W-1:0]    utc_month = '0;
    logic [DAY_W-1:0]      utc_day = '0;
    logic [HOUR_W-1:0]     utc_hour = '0;
    logic [MINUTE_W-1:0]   utc_minute = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [YEAR_W-1:0]     local_year;
    logic [MONTH_W-1:0]    local_month;
    logic [DAY_W-1:0]      local_day;
    logic [HOUR_W-1:0]     shown_hour;
    logic [MINUTE_W-1:0]   local_minute;
    logic                  is_pm;
    logic                  date_valid;

    // Asks the receiver for one long hold-off
    bit   hold_off_req = 1'b0;
    int   idle_cycles = 0;
    cfg_t settings = '{utc_offset_biased: OFFSET_RESET, use_twelve_hour: 1'b0};

    utc_offset_local_date_time_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .utc_year     (utc_year),
        .utc_month    (utc_month),
        .utc_day      (utc_day),
        .utc_hour     (utc_hour),
        .utc_minute   (utc_minute),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .local_year   (local_year),
        .local_month  (local_month),
        .local_day    (local_day),
        .shown_hour   (shown_hour),
        .local_minute (local_minute),
        .is_pm        (is_pm),
        .date_valid   (date_valid)
    );

    class LocalTimeLedger;
        local_item_t awaited_local[$];
        int          errors = 0;

        static function int unsigned days_in(int unsigned y, int unsigned m);
            int unsigned lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            bit          leap;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m < 1 || m > 12)
                return 0;
            if (m == 2 && leap)
                return 29;
            return lengths[m - 1];
        endfunction

        function local_item_t local_from_utc(utc_item_t u, cfg_t c);
            local_item_t r;
            int unsigned yr;
            int unsigned mo;
            int unsigned dy;
            int unsigned quarters;
            int unsigned h24;
            int unsigned twelve;
            int          total;
            int          wrapped;
            yr = u.year;
            mo = u.month;
            dy = u.day;
            quarters = (c.utc_offset_biased > OFFSET_CLAMP) ? OFFSET_CLAMP
                                                            : c.utc_offset_biased;
            total = int'(u.hour) * 60 + int'(u.minute)
                  + (int'(quarters) - QUARTER_BIAS) * 15;
            wrapped = ((total % MINUTES_A_DAY) + MINUTES_A_DAY) % MINUTES_A_DAY;
            h24 = wrapped / 60;

            if (total >= MINUTES_A_DAY) begin
                if (dy < days_in(yr, mo)) begin
                    dy++;
                end else begin
                    dy = 1;
                    if (mo == MONTH_DEC) begin
                        mo = MONTH_JAN;
                        yr = (yr + 1) & 'h3FFF;
                    end else begin
                        mo = (mo + 1) & 'hF;
                    end
                end
            end else if (total < 0) begin
                if (dy > 1) begin
                    dy--;
                end else begin
                    if (mo == MONTH_JAN) begin
                        mo = MONTH_DEC;
                        yr = (yr - 1) & 'h3FFF;
                    end else begin
                        mo = (mo - 1) & 'hF;
                    end
                    dy = days_in(yr, mo);
                end
            end

            twelve = (h24 % 12 == 0) ? 12 : h24 % 12;
            r.year       = yr[YEAR_W-1:0];
            r.month      = mo[MONTH_W-1:0];
            r.day        = dy[DAY_W-1:0];
            r.shown_hour = c.use_twelve_hour ? twelve[HOUR_W-1:0] : h24[HOUR_W-1:0];
            r.minute     = 6'(wrapped % 60);
            r.is_pm      = (h24 >= 12);
            r.date_valid = (mo >= 1) && (mo <= 12) && (dy >= 1) && (dy <= days_in(yr, mo));
            return r;
        endfunction

        function void note_input(utc_item_t u, cfg_t c);
            awaited_local.push_back(local_from_utc(u, c));
        endfunction

        function int count();
            return awaited_local.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(local_item_t got);
            local_item_t want;
            if (awaited_local.size() == 0) begin
                report("local beat with nothing awaited");
                return;
            end
            want = awaited_local.pop_front();
            compare_field("local_year", 16'(got.year), 16'(want.year));
            compare_field("local_month", 16'(got.month), 16'(want.month));
            compare_field("local_day", 16'(got.day), 16'(want.day));
            compare_field("shown_hour", 16'(got.shown_hour), 16'(want.shown_hour));
            compare_field("local_minute", 16'(got.minute), 16'(want.minute));
            compare_field("is_pm", 16'(got.is_pm), 16'(want.is_pm));
            compare_field("date_valid", 16'(got.date_valid), 16'(want.date_valid));
        endtask
    endclass

    LocalTimeLedger ledger = new();

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output checking and the no-progress watchdog
    always @(posedge clk)
    begin : watch
        local_item_t seen;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                seen.year       = local_year;
                seen.month      = local_month;
                seen.day        = local_day;
                seen.shown_hour = shown_hour;
                seen.minute     = local_minute;
                seen.is_pm      = is_pm;
                seen.date_valid = date_valid;
                ledger.check_result(seen);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("utc_offset_local_date_time_core verification failed");
                $finish;
            end
        end
    end

    // Receiver: segments of free flow, random stalls and solid stalls
    initial
    begin : receiver
        int kind;
        int len;
        int pct;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_off_req) begin
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
                hold_off_req = 1'b0;
            end else begin
                kind = $urandom_range(0, 2);
                len  = (kind == 2) ? $urandom_range(1, 12) : $urandom_range(4, 40);
                pct  = $urandom_range(10, 80);
                repeat (len) begin
                    case (kind)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < pct);
                        default: out_stall <= 1'b1;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    function automatic utc_item_t mk(int y, int m, int d, int h, int mi);
        utc_item_t u;
        u.year   = YEAR_W'(y);
        u.month  = MONTH_W'(m);
        u.day    = DAY_W'(d);
        u.hour   = HOUR_W'(h);
        u.minute = MINUTE_W'(mi);
        return u;
    endfunction

    // Mostly real dates near month and day edges; the rest is raw noise
    function automatic utc_item_t random_utc();
        int unsigned y;
        int unsigned m;
        int unsigned len;
        int unsigned d;
        int unsigned h;
        if ($urandom_range(0, 99) < 15)
            return mk($urandom, $urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 5))
            0: y = $urandom_range(1, 2499) * 4;
            1: y = $urandom_range(1, 99) * 100;
            2: y = $urandom_range(1, 24) * 400;
            3: y = $urandom_range(0, 1) ? 1 : 9999;
            default: y = $urandom_range(1, 9999);
        endcase
        m = $urandom_range(1, 12);
        len = LocalTimeLedger::days_in(y, m);
        case ($urandom_range(0, 4))
            0: d = 1;
            1: d = 2;
            2: d = len - 1;
            3: d = len;
            default: d = $urandom_range(1, len);
        endcase
        case ($urandom_range(0, 2))
            0: h = $urandom_range(0, 2);
            1: h = $urandom_range(21, 23);
            default: h = $urandom_range(0, 23);
        endcase
        return mk(y, m, d, h, $urandom_range(0, 59));
    endfunction

    task automatic set_config(input logic [OFFSET_W-1:0] offset, input logic twelve);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UTC_OFFSET;
        cfg_wdata <= offset;
        @(posedge clk);
        cfg_index <= REG_USE_TWELVE_HOUR;
        cfg_wdata <= {7'($urandom_range(0, 127)), twelve};
        @(posedge clk);
        cfg_we <= 1'b0;
        settings.utc_offset_biased = offset;
        settings.use_twelve_hour   = twelve;
    endtask

    task automatic send(input utc_item_t it);
        in_valid   <= 1'b1;
        utc_year   <= it.year;
        utc_month  <= it.month;
        utc_day    <= it.day;
        utc_hour   <= it.hour;
        utc_minute <= it.minute;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        ledger.note_input(it, settings);
    endtask

    task automatic pause(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Only called right after a beat, so at least one result is awaited
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (ledger.count() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int n, input bit gapped);
        int burst;
        burst = $urandom_range(1, 24);
        repeat (n) begin
            send(random_utc());
            burst--;
            if (burst == 0 && gapped) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 19) == 0)
                    wait_for_results();
                else
                    pause($urandom_range(1, 8));
            end
        end
        wait_for_results();
    endtask

    initial
    begin : main
        logic [OFFSET_W-1:0] offset;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no shift, 24-hour form
        send(mk(1, 1, 1, 0, 0));
        send(mk(9999, 12, 31, 23, 59));
        send(mk(16383, 15, 31, 31, 63));
        wait_for_results();

        // +14:00, twelve-hour: forward across day, month, year and leap edges, and bad fields
        set_config(OFFSET_CLAMP, 1'b1);
        send(mk(9999, 12, 31, 23, 0));
        send(mk(16383, 12, 31, 12, 0));
        send(mk(2000, 2, 28, 20, 0));
        send(mk(1900, 2, 28, 20, 0));
        send(mk(2024, 2, 29, 11, 0));
        send(mk(2023, 4, 30, 10, 0));
        send(mk(2023, 4, 31, 15, 0));
        send(mk(2023, 15, 31, 15, 0));
        send(mk(2023, 0, 5, 15, 0));
        send(mk(2023, 6, 10, 9, 59));
        send(mk(2023, 6, 10, 31, 63));
        wait_for_results();

        // -12:00: backward edges, bad months and day zero
        set_config('0, 1'b0);
        send(mk(1, 1, 1, 0, 0));
        send(mk(0, 1, 1, 0, 0));
        send(mk(2000, 3, 1, 5, 0));
        send(mk(2100, 3, 1, 5, 0));
        send(mk(2023, 0, 1, 3, 0));
        send(mk(2023, 13, 0, 3, 0));
        send(mk(2023, 1, 0, 3, 0));
        send(mk(2023, 7, 15, 11, 59));
        send(mk(2023, 7, 15, 12, 0));
        wait_for_results();

        // Offset above the clamp behaves as +14:00
        set_config(8'd255, 1'b1);
        send(mk(2023, 7, 15, 10, 0));
        send(mk(2023, 7, 15, 0, 0));
        wait_for_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: offset = '0;
                1: offset = OFFSET_CLAMP;
                2: offset = 8'd255;
                4: offset = OFFSET_RESET;
                6: offset = OFFSET_CLAMP + 8'd1;
                default: offset = OFFSET_W'($urandom_range(0, 255));
            endcase
            set_config(offset, p[0]);
            // Phase 2 runs flat out into a long receiver hold-off
            if (p == 2)
                hold_off_req = 1'b1;
            run_random(PHASE_ITEMS, !(p == 2 || p == 5));
        end

        repeat (8) @(posedge clk);
        if (ledger.count() != 0)
            ledger.report($sformatf("%0d local beats never arrived", ledger.count()));
        if (ledger.errors == 0)
            $display("utc_offset_local_date_time_core verification clean");
        else
            $display("utc_offset_local_date_time_core verification failed");
        $finish;
    end

endmodule
